// ----- hw/rtl/lcdt_pkg.sv -----
// Shared types and constants for the LCD draw command translator.
// Used by lcdt_front, lcdt_queue, lcdt_back, the top level and the checker.
// No dependencies.
`default_nettype none

package lcdt_pkg;

  localparam int DEF_PANEL_WIDTH  = 240;
  localparam int DEF_PANEL_HEIGHT = 320;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // Coordinates after clamping fit panels up to 1024 on a side.
  localparam int COORD_W = 10;
  localparam int CNT_W   = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] REG_ENTRY  = 8'h03;
  localparam logic [7:0] REG_ADDR_X = 8'h20;
  localparam logic [7:0] REG_ADDR_Y = 8'h21;
  localparam logic [7:0] REG_DATA   = 8'h22;
  localparam logic [7:0] REG_HSTART = 8'h50;
  localparam logic [7:0] REG_HEND   = 8'h51;
  localparam logic [7:0] REG_VSTART = 8'h52;
  localparam logic [7:0] REG_VEND   = 8'h53;

  localparam logic [15:0] ENTRY_LANDSCAPE      = 16'h1028;
  localparam logic [15:0] ENTRY_PORTRAIT_FLIP  = 16'h1000;
  localparam logic [15:0] ENTRY_LANDSCAPE_FLIP = 16'h1018;
  localparam logic [15:0] ENTRY_DEFAULT        = 16'h1030;

  localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
  localparam logic [1:0] ORIENT_LANDSCAPE      = 2'd1;
  localparam logic [1:0] ORIENT_PORTRAIT_FLIP  = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;
  localparam logic [1:0] ORIENT_RESET          = ORIENT_LANDSCAPE;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FILL  = 1'b1;

  // Classified command: clamped, ordered corners in logical coordinates.
  typedef struct packed {
    logic               cmd;
    logic [1:0]         orient;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [15:0]        color;
  } cmd_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdt_front.sv -----
// Front part: classifies a drawing command, drops off-screen pixels,
// clamps and orders rectangle corners. Depends on lcdt_pkg.
`default_nettype none

module lcdt_front #(
  parameter int PANEL_WIDTH  = lcdt_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = lcdt_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic signed [15:0] x_first,
  input  wire logic signed [15:0] y_first,
  input  wire logic signed [15:0] x_second,
  input  wire logic signed [15:0] y_second,
  input  wire logic [15:0]        color,
  input  wire logic [1:0]         orientation,
  output logic                    push,
  output lcdt_pkg::cmd_entry_t    entry,
  input  wire logic               q_ready
);

  localparam logic [lcdt_pkg::COORD_W-1:0] PW_M1 = lcdt_pkg::COORD_W'(PANEL_WIDTH - 1);
  localparam logic [lcdt_pkg::COORD_W-1:0] PH_M1 = lcdt_pkg::COORD_W'(PANEL_HEIGHT - 1);

  function automatic logic above(input logic signed [15:0] v,
                                 input logic [lcdt_pkg::COORD_W-1:0] hi);
    logic signed [16:0] hs;
    hs = $signed({{(17 - lcdt_pkg::COORD_W){1'b0}}, hi});
    return 17'(v) > hs;
  endfunction

  function automatic logic [lcdt_pkg::COORD_W-1:0] clamp(
      input logic signed [15:0] v, input logic [lcdt_pkg::COORD_W-1:0] hi);
    logic [lcdt_pkg::COORD_W-1:0] r;
    if (v[15]) begin
      r = '0;
    end else if (above(v, hi)) begin
      r = hi;
    end else begin
      r = v[lcdt_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  logic [lcdt_pkg::COORD_W-1:0] x_hi, y_hi;
  logic [lcdt_pkg::COORD_W-1:0] cx0, cx1, cy0, cy1;
  logic                         on_screen;

  assign x_hi = orientation[0] ? PH_M1 : PW_M1;
  assign y_hi = orientation[0] ? PW_M1 : PH_M1;

  assign cx0 = clamp(x_first, x_hi);
  assign cy0 = clamp(y_first, y_hi);
  assign cx1 = clamp(x_second, x_hi);
  assign cy1 = clamp(y_second, y_hi);

  assign on_screen = !x_first[15] && !y_first[15] &&
                     !above(x_first, x_hi) && !above(y_first, y_hi);

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && (command == lcdt_pkg::CMD_FILL || on_screen);

  always_comb begin
    entry.cmd    = command;
    entry.orient = orientation;
    entry.color  = color;
    if (command == lcdt_pkg::CMD_PIXEL) begin
      entry.x0 = cx0;
      entry.x1 = cx0;
      entry.y0 = cy0;
      entry.y1 = cy0;
    end else begin
      entry.x0 = (cx1 < cx0) ? cx1 : cx0;
      entry.x1 = (cx1 < cx0) ? cx0 : cx1;
      entry.y0 = (cy1 < cy0) ? cy1 : cy0;
      entry.y1 = (cy1 < cy0) ? cy0 : cy1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdt_queue.sv -----
// Short queue of classified commands between front and back parts.
// Depends on lcdt_pkg.
`default_nettype none

module lcdt_queue #(
  parameter int DEPTH = lcdt_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lcdt_pkg::cmd_entry_t push_entry,
  output logic                      q_ready,
  input  wire logic                 pop,
  output logic                      q_valid,
  output lcdt_pkg::cmd_entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  lcdt_pkg::cmd_entry_t slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;

  assign q_ready = count != CNT_W'(DEPTH);
  assign q_valid = count != '0;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdt_back.sv -----
// Back part: rotates a classified command and sequences the controller
// register writes into a registered output. Depends on lcdt_pkg.
`default_nettype none

module lcdt_back #(
  parameter int PANEL_WIDTH  = lcdt_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = lcdt_pkg::DEF_PANEL_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire lcdt_pkg::cmd_entry_t head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                reg_addr,
  output logic [15:0]               reg_value,
  output logic [lcdt_pkg::CNT_W-1:0] repeat_count,
  output logic                      last
);

  localparam int CW = lcdt_pkg::COORD_W;
  localparam logic [CW-1:0] PW_M1 = CW'(PANEL_WIDTH - 1);
  localparam logic [CW-1:0] PH_M1 = CW'(PANEL_HEIGHT - 1);

  localparam logic [3:0] S_ENTRY     = 4'd0;
  localparam logic [3:0] S_HSTART    = 4'd1;
  localparam logic [3:0] S_HEND      = 4'd2;
  localparam logic [3:0] S_VSTART    = 4'd3;
  localparam logic [3:0] S_VEND      = 4'd4;
  localparam logic [3:0] S_ADDR_X    = 4'd5;
  localparam logic [3:0] S_ADDR_Y    = 4'd6;
  localparam logic [3:0] S_DATA      = 4'd7;
  localparam logic [3:0] S_RST_ENTRY = 4'd8;
  localparam logic [3:0] S_RST_HS    = 4'd9;
  localparam logic [3:0] S_RST_HE    = 4'd10;
  localparam logic [3:0] S_RST_VS    = 4'd11;
  localparam logic [3:0] S_RST_VE    = 4'd12;
  localparam logic [3:0] S_PX_X      = 4'd13;
  localparam logic [3:0] S_PX_Y      = 4'd14;
  localparam logic [3:0] S_PX_DATA   = 4'd15;

  logic          busy;
  logic [3:0]    step;
  logic [1:0]    orient;
  logic [CW-1:0] ax0, ax1, ay0, ay1;
  logic [CW:0]   w, h;
  logic [15:0]   color;
  logic [lcdt_pkg::CNT_W-1:0] cnt;

  logic [CW-1:0] ax0_next, ax1_next, ay0_next, ay1_next;
  logic [3:0]    start_step;
  logic          step_last, advance;
  logic [2*CW+1:0] prod;

  logic [7:0]  w_addr;
  logic [15:0] w_value;
  logic        w_burst;

  always_comb begin
    unique case (head.orient)
      lcdt_pkg::ORIENT_LANDSCAPE: begin
        ax0_next = PW_M1 - head.y1;
        ax1_next = PW_M1 - head.y0;
        ay0_next = head.x0;
        ay1_next = head.x1;
      end
      lcdt_pkg::ORIENT_PORTRAIT_FLIP: begin
        ax0_next = PW_M1 - head.x1;
        ax1_next = PW_M1 - head.x0;
        ay0_next = PH_M1 - head.y1;
        ay1_next = PH_M1 - head.y0;
      end
      lcdt_pkg::ORIENT_LANDSCAPE_FLIP: begin
        ax0_next = head.y0;
        ax1_next = head.y1;
        ay0_next = PH_M1 - head.x1;
        ay1_next = PH_M1 - head.x0;
      end
      default: begin
        ax0_next = head.x0;
        ax1_next = head.x1;
        ay0_next = head.y0;
        ay1_next = head.y1;
      end
    endcase
  end

  always_comb begin
    if (head.cmd == lcdt_pkg::CMD_PIXEL) begin
      start_step = S_PX_X;
    end else if (head.orient == lcdt_pkg::ORIENT_PORTRAIT) begin
      start_step = S_HSTART;
    end else begin
      start_step = S_ENTRY;
    end
  end

  assign step_last = (step == S_RST_VE) || (step == S_PX_DATA);
  assign advance   = busy && (!out_valid || out_ready);
  assign pop       = q_valid && (!busy || (advance && step_last));
  assign prod      = w * h;

  always_comb begin
    w_burst = 1'b0;
    unique case (step)
      S_ENTRY: begin
        w_addr = lcdt_pkg::REG_ENTRY;
        unique case (orient)
          lcdt_pkg::ORIENT_LANDSCAPE:     w_value = lcdt_pkg::ENTRY_LANDSCAPE;
          lcdt_pkg::ORIENT_PORTRAIT_FLIP: w_value = lcdt_pkg::ENTRY_PORTRAIT_FLIP;
          default:                        w_value = lcdt_pkg::ENTRY_LANDSCAPE_FLIP;
        endcase
      end
      S_HSTART:    begin w_addr = lcdt_pkg::REG_HSTART; w_value = 16'(ax0); end
      S_HEND:      begin w_addr = lcdt_pkg::REG_HEND;   w_value = 16'(ax1); end
      S_VSTART:    begin w_addr = lcdt_pkg::REG_VSTART; w_value = 16'(ay0); end
      S_VEND:      begin w_addr = lcdt_pkg::REG_VEND;   w_value = 16'(ay1); end
      S_ADDR_X:    begin w_addr = lcdt_pkg::REG_ADDR_X; w_value = 16'(ax0); end
      S_ADDR_Y:    begin w_addr = lcdt_pkg::REG_ADDR_Y; w_value = 16'(ay0); end
      S_DATA: begin
        w_addr  = lcdt_pkg::REG_DATA;
        w_value = color;
        w_burst = 1'b1;
      end
      S_RST_ENTRY: begin w_addr = lcdt_pkg::REG_ENTRY;  w_value = lcdt_pkg::ENTRY_DEFAULT; end
      S_RST_HS:    begin w_addr = lcdt_pkg::REG_HSTART; w_value = '0; end
      S_RST_HE:    begin w_addr = lcdt_pkg::REG_HEND;   w_value = 16'(PW_M1); end
      S_RST_VS:    begin w_addr = lcdt_pkg::REG_VSTART; w_value = '0; end
      S_RST_VE:    begin w_addr = lcdt_pkg::REG_VEND;   w_value = 16'(PH_M1); end
      S_PX_X:      begin w_addr = lcdt_pkg::REG_ADDR_X; w_value = 16'(ax0); end
      S_PX_Y:      begin w_addr = lcdt_pkg::REG_ADDR_Y; w_value = 16'(ay0); end
      S_PX_DATA:   begin w_addr = lcdt_pkg::REG_DATA;   w_value = color; end
      default:     begin w_addr = lcdt_pkg::REG_DATA;   w_value = color; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      orient <= head.orient;
      color  <= head.color;
      ax0    <= ax0_next;
      ax1    <= ax1_next;
      ay0    <= ay0_next;
      ay1    <= ay1_next;
      w      <= {1'b0, head.x1} - {1'b0, head.x0} + 1'b1;
      h      <= {1'b0, head.y1} - {1'b0, head.y0} + 1'b1;
    end
    cnt <= (prod > (2*CW+2)'(lcdt_pkg::CNT_MAX)) ? lcdt_pkg::CNT_MAX
                                                 : prod[lcdt_pkg::CNT_W-1:0];
    if (advance) begin
      reg_addr     <= w_addr;
      reg_value    <= w_value;
      repeat_count <= w_burst ? cnt : lcdt_pkg::CNT_W'(1);
      last         <= step_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= S_ENTRY;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= start_step;
      end else if (advance) begin
        busy <= !step_last;
        step <= step + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcd_draw_command_translator.sv -----
// Top level of the LCD draw command translator: orientation register,
// front classifier, command queue and write sequencer.
// Depends on lcdt_pkg, lcdt_front, lcdt_queue, lcdt_back.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_ready    command, x/y first, x/y second, color
//   out       output      out_valid / out_ready  reg_addr, reg_value, repeat_count, last
//   cfg       input       cfg_valid / cfg_ready  cfg_data (orientation)
//
// One register write leaves per cycle unless the output stalls; a fill in
// portrait skips the entry-mode write. The write sequencer sets the rate, and a
// queued command is popped as the last write of the previous one is registered.
// A command goes via a queue slot and the sequencer state to the output register.
// Off-screen pixels are dropped at the front: accepted, but never queued.
// Reset sets orientation to landscape and empties queue and sequencer.
// A stalled output holds the sequencer; input keeps flowing until the queue fills.
`default_nettype none

module lcd_draw_command_translator #(
  parameter int PANEL_WIDTH  = lcdt_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = lcdt_pkg::DEF_PANEL_HEIGHT,
  parameter int QUEUE_DEPTH  = lcdt_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic signed [15:0] x_first,
  input  wire logic signed [15:0] y_first,
  input  wire logic signed [15:0] x_second,
  input  wire logic signed [15:0] y_second,
  input  wire logic [15:0]        color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              reg_addr,
  output logic [15:0]             reg_value,
  output logic [16:0]             repeat_count,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_data
);

  logic [1:0]           orientation;
  logic                 push, pop, q_ready, q_valid;
  lcdt_pkg::cmd_entry_t push_entry, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= lcdt_pkg::ORIENT_RESET;
    end else if (cfg_valid) begin
      orientation <= cfg_data;
    end
  end

  lcdt_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .x_first     (x_first),
    .y_first     (y_first),
    .x_second    (x_second),
    .y_second    (y_second),
    .color       (color),
    .orientation (orientation),
    .push        (push),
    .entry       (push_entry),
    .q_ready     (q_ready)
  );

  lcdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  lcdt_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reg_addr     (reg_addr),
    .reg_value    (reg_value),
    .repeat_count (repeat_count),
    .last         (last)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lcdt_checker.sv -----
// Port-level checks for the LCD draw command translator, bound to the top.
// Depends on lcdt_pkg and lcd_draw_command_translator.
`default_nettype none

module lcdt_checker #(
  parameter int PANEL_HEIGHT = lcdt_pkg::DEF_PANEL_HEIGHT
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  reg_addr,
  input wire logic [15:0] reg_value,
  input wire logic [16:0] repeat_count,
  input wire logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reg_addr) &&
      $stable(reg_value) && $stable(repeat_count) && $stable(last))
    else $error("output word changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != '0)
    else $error("zero repeat count");

  a_burst_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_count != 17'd1 |-> reg_addr == lcdt_pkg::REG_DATA && !last)
    else $error("burst on a non-data write or at end of sequence");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |->
      (reg_addr == lcdt_pkg::REG_DATA && repeat_count == 17'd1) ||
      (reg_addr == lcdt_pkg::REG_VEND && reg_value == 16'(PANEL_HEIGHT - 1)))
    else $error("sequence ended on an unexpected write");

endmodule

bind lcd_draw_command_translator lcdt_checker #(
  .PANEL_HEIGHT (PANEL_HEIGHT)
) u_lcdt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .reg_addr     (reg_addr),
  .reg_value    (reg_value),
  .repeat_count (repeat_count),
  .last         (last)
);

`default_nettype wire

// ----- tb/lcd_draw_command_translator_tb.sv -----
// Testbench for lcd_draw_command_translator: drives pixel and fill commands
// under all orientations and checks every register write against a predictor.
// Depends on lcdt_pkg and the lcd_draw_command_translator RTL.
`default_nettype none

module lcd_draw_command_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W     = lcdt_pkg::DEF_PANEL_WIDTH;
  localparam int PANEL_H     = lcdt_pkg::DEF_PANEL_HEIGHT;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic [7:0]                 addr;
    logic [15:0]                value;
    logic [lcdt_pkg::CNT_W-1:0] count;
    logic                       last;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic command;
  logic signed [15:0] x_first;
  logic signed [15:0] y_first;
  logic signed [15:0] x_second;
  logic signed [15:0] y_second;
  logic [15:0] color;
  logic out_valid;
  logic out_ready;
  logic [7:0] reg_addr;
  logic [15:0] reg_value;
  logic [16:0] repeat_count;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_data;

  reg_write_t pending_writes[$];
  logic [1:0] orient_model;
  int         error_count = 0;
  int         cycle_count = 0;

  lcd_draw_command_translator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .x_first      (x_first),
    .y_first      (y_first),
    .x_second     (x_second),
    .y_second     (y_second),
    .color        (color),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reg_addr     (reg_addr),
    .reg_value    (reg_value),
    .repeat_count (repeat_count),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int logical_w();
    return orient_model[0] ? PANEL_H : PANEL_W;
  endfunction

  function automatic int logical_h();
    return orient_model[0] ? PANEL_W : PANEL_H;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_write(logic [7:0] addr, int value, int count, logic is_last);
    reg_write_t w;
    w.addr  = addr;
    w.value = value[15:0];
    w.count = count[lcdt_pkg::CNT_W-1:0];
    w.last  = is_last;
    pending_writes.push_back(w);
  endfunction

  // Expected register writes of one accepted command.
  function automatic void predict_writes(logic cmd, logic signed [15:0] xa,
                                         logic signed [15:0] ya, logic signed [15:0] xb,
                                         logic signed [15:0] yb, logic [15:0] col);
    int lw, lh, x0, y0, x1, y1, t, ax0, ax1, ay0, ay1, px, py, cnt;
    lw = logical_w();
    lh = logical_h();
    x0 = int'(xa);
    y0 = int'(ya);
    x1 = int'(xb);
    y1 = int'(yb);
    if (cmd == lcdt_pkg::CMD_PIXEL) begin
      if (x0 < 0 || x0 >= lw || y0 < 0 || y0 >= lh) return;
      case (orient_model)
        lcdt_pkg::ORIENT_LANDSCAPE: begin
          px = PANEL_W - 1 - y0;
          py = x0;
        end
        lcdt_pkg::ORIENT_PORTRAIT_FLIP: begin
          px = PANEL_W - 1 - x0;
          py = PANEL_H - 1 - y0;
        end
        lcdt_pkg::ORIENT_LANDSCAPE_FLIP: begin
          px = y0;
          py = PANEL_H - 1 - x0;
        end
        default: begin
          px = x0;
          py = y0;
        end
      endcase
      push_write(lcdt_pkg::REG_ADDR_X, px, 1, 1'b0);
      push_write(lcdt_pkg::REG_ADDR_Y, py, 1, 1'b0);
      push_write(lcdt_pkg::REG_DATA, int'(col), 1, 1'b1);
      return;
    end
    x0 = clamp_coord(x0, lw - 1);
    x1 = clamp_coord(x1, lw - 1);
    y0 = clamp_coord(y0, lh - 1);
    y1 = clamp_coord(y1, lh - 1);
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (y1 < y0) begin
      t = y0; y0 = y1; y1 = t;
    end
    case (orient_model)
      lcdt_pkg::ORIENT_LANDSCAPE: begin
        push_write(lcdt_pkg::REG_ENTRY, int'(lcdt_pkg::ENTRY_LANDSCAPE), 1, 1'b0);
        ax0 = PANEL_W - 1 - y1; ax1 = PANEL_W - 1 - y0; ay0 = x0; ay1 = x1;
      end
      lcdt_pkg::ORIENT_PORTRAIT_FLIP: begin
        push_write(lcdt_pkg::REG_ENTRY, int'(lcdt_pkg::ENTRY_PORTRAIT_FLIP), 1, 1'b0);
        ax0 = PANEL_W - 1 - x1; ax1 = PANEL_W - 1 - x0;
        ay0 = PANEL_H - 1 - y1; ay1 = PANEL_H - 1 - y0;
      end
      lcdt_pkg::ORIENT_LANDSCAPE_FLIP: begin
        push_write(lcdt_pkg::REG_ENTRY, int'(lcdt_pkg::ENTRY_LANDSCAPE_FLIP), 1, 1'b0);
        ax0 = y0; ax1 = y1; ay0 = PANEL_H - 1 - x1; ay1 = PANEL_H - 1 - x0;
      end
      default: begin
        ax0 = x0; ax1 = x1; ay0 = y0; ay1 = y1;
      end
    endcase
    push_write(lcdt_pkg::REG_HSTART, ax0, 1, 1'b0);
    push_write(lcdt_pkg::REG_HEND, ax1, 1, 1'b0);
    push_write(lcdt_pkg::REG_VSTART, ay0, 1, 1'b0);
    push_write(lcdt_pkg::REG_VEND, ay1, 1, 1'b0);
    push_write(lcdt_pkg::REG_ADDR_X, ax0, 1, 1'b0);
    push_write(lcdt_pkg::REG_ADDR_Y, ay0, 1, 1'b0);
    cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
    if (cnt > int'(lcdt_pkg::CNT_MAX)) cnt = int'(lcdt_pkg::CNT_MAX);
    push_write(lcdt_pkg::REG_DATA, int'(col), cnt, 1'b0);
    push_write(lcdt_pkg::REG_ENTRY, int'(lcdt_pkg::ENTRY_DEFAULT), 1, 1'b0);
    push_write(lcdt_pkg::REG_HSTART, 0, 1, 1'b0);
    push_write(lcdt_pkg::REG_HEND, PANEL_W - 1, 1, 1'b0);
    push_write(lcdt_pkg::REG_VSTART, 0, 1, 1'b0);
    push_write(lcdt_pkg::REG_VEND, PANEL_H - 1, 1, 1'b1);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    reg_write_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t unexpected word: expected none actual addr %h value %h count %h last %b",
                 $time, reg_addr, reg_value, repeat_count, last);
        error_count++;
      end else begin
        w = pending_writes.pop_front();
        check_field("reg_addr", w.addr, reg_addr);
        check_field("reg_value", w.value, reg_value);
        check_field("repeat_count", w.count, repeat_count);
        check_field("last", w.last, last);
      end
    end
  end

  initial begin
    int burst, stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      burst = ($urandom_range(0, 9) < 2) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      stall = gap_cycles();
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_command(logic cmd, logic signed [15:0] xa, logic signed [15:0] ya,
                              logic signed [15:0] xb, logic signed [15:0] yb,
                              logic [15:0] col);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    x_first  <= xa;
    y_first  <= ya;
    x_second <= xb;
    y_second <= yb;
    color    <= col;
    do @(posedge clk); while (!in_ready);
    predict_writes(cmd, xa, ya, xb, yb, col);
  endtask

  // Drop valid, drain results, then cover a dropped pixel still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_orientation(logic [1:0] o);
    wait_idle();
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= o;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    orient_model = o;
  endtask

  function automatic logic signed [15:0] rand_coord(int size);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'(unsigned'($urandom_range(0, size - 1)));
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return -16'sd1;
        1: return 16'sd0;
        2: return 16'(size - 1);
        default: return 16'(size);
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic test_reset_orientation();
    send_command(lcdt_pkg::CMD_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
    send_command(lcdt_pkg::CMD_PIXEL, 16'(PANEL_H - 1), 16'(PANEL_W - 1), 16'sd5, 16'sd5,
                 16'hFFFF);
    send_command(lcdt_pkg::CMD_PIXEL, 16'(PANEL_H), 16'sd0, 16'sd0, 16'sd0, 16'h1234);
    send_command(lcdt_pkg::CMD_FILL, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'hA5A5);
  endtask

  task automatic test_pixel_bounds();
    logic [1:0] o;
    int lw, lh;
    for (int i = 0; i < 4; i++) begin
      o = 2'(i);
      write_orientation(o);
      lw = logical_w();
      lh = logical_h();
      send_command(lcdt_pkg::CMD_PIXEL, 16'(lw - 1), 16'sd0, -16'sh8000, 16'sh7FFF, 16'hFFFF);
      send_command(lcdt_pkg::CMD_PIXEL, 16'sd0, 16'(lh - 1), 16'sh7FFF, -16'sh8000, 16'h0000);
      send_command(lcdt_pkg::CMD_PIXEL, -16'sd1, 16'sd3, 16'sd0, 16'sd0, 16'h5A5A);
      send_command(lcdt_pkg::CMD_PIXEL, 16'sd3, 16'(lh), 16'sd0, 16'sd0, 16'h00FF);
    end
  endtask

  task automatic test_fill_clamping();
    write_orientation(lcdt_pkg::ORIENT_PORTRAIT);
    send_command(lcdt_pkg::CMD_FILL, 16'sd200, 16'sd300, 16'sd10, 16'sd20, 16'h0F0F);
    send_command(lcdt_pkg::CMD_FILL, -16'sd5, -16'sd9, -16'sh8000, -16'sd1, 16'hF0F0);
    write_orientation(lcdt_pkg::ORIENT_LANDSCAPE_FLIP);
    send_command(lcdt_pkg::CMD_FILL, 16'sh7FFF, 16'sh7FFF, 16'sd400, 16'sd300, 16'hFFFF);
    send_command(lcdt_pkg::CMD_FILL, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'h0000);
  endtask

  task automatic test_random_commands(int total);
    logic [1:0] plan[5];
    int lw, lh;
    plan[0] = lcdt_pkg::ORIENT_PORTRAIT;
    plan[1] = lcdt_pkg::ORIENT_LANDSCAPE_FLIP;
    plan[2] = 2'($urandom);
    plan[3] = lcdt_pkg::ORIENT_PORTRAIT_FLIP;
    plan[4] = 2'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_orientation(plan[p]);
      lw = logical_w();
      lh = logical_h();
      for (int n = 0; n < total / 5; n++) begin
        send_command(1'($urandom), rand_coord(lw), rand_coord(lh), rand_coord(lw),
                     rand_coord(lh), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    command      <= lcdt_pkg::CMD_PIXEL;
    x_first      <= '0;
    y_first      <= '0;
    x_second     <= '0;
    y_second     <= '0;
    color        <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= lcdt_pkg::ORIENT_RESET;
    orient_model = lcdt_pkg::ORIENT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_orientation();
    test_pixel_bounds();
    test_fill_clamping();
    test_random_commands(470);

    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
